// ===== hw/rtl/limit_switch_motor_controller_unit_defines.svh =====
// Assertion macros for the limit switch motor controller.
`ifndef LIMIT_SWITCH_MOTOR_CONTROLLER_UNIT_DEFINES_SVH
`define LIMIT_SWITCH_MOTOR_CONTROLLER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold on every clock edge out of reset.
`define LSMC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("lsmc assertion failed");

// Condition must never be seen on a clock edge out of reset.
`define LSMC_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("lsmc forbidden condition seen");

`else

`define LSMC_ASSERT(label, clk, rst_n, prop)
`define LSMC_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== hw/rtl/lsmc_pkg.sv =====
// Types and constants shared by the limit switch motor controller modules.
`default_nettype none

package lsmc_pkg;

  // Request commands
  typedef enum logic [2:0] {
    CMD_STEP           = 3'd0,
    CMD_TICK_10MS      = 3'd1,
    CMD_TICK_100MS     = 3'd2,
    CMD_PRESET_STRETCH = 3'd3,
    CMD_PRESET_ELAPSED = 3'd4
  } lsmc_cmd_e;

  // Run modes
  typedef enum logic [2:0] {
    MODE_IDLE          = 3'd0,
    MODE_IN            = 3'd1,
    MODE_RESET         = 3'd2,
    MODE_STRETCH_RESET = 3'd3,
    MODE_OUT           = 3'd4,
    MODE_STRETCH_OUT   = 3'd5,
    MODE_MANUAL_OUT    = 3'd6,
    MODE_TEST_OUT      = 3'd7
  } lsmc_mode_e;

  // Stop reasons
  typedef enum logic [3:0] {
    STAT_RUN        = 4'd0,
    STAT_AT_IN      = 4'd1,
    STAT_AT_FOOT    = 4'd2,
    STAT_AT_OUT     = 4'd3,
    STAT_ANGLE      = 4'd4,
    STAT_GROUND     = 4'd5,
    STAT_FOOT_LEFT  = 4'd6,
    STAT_IDLE       = 4'd7,
    STAT_STRETCH_TO = 4'd8
  } lsmc_status_e;

  // Sticky end position
  typedef enum logic [1:0] {
    END_NONE = 2'd0,
    END_IN   = 2'd1,
    END_OUT  = 2'd2
  } lsmc_end_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_FOOT_DWELL     = 3'd0,
    CFG_IN_TIMEOUT     = 3'd1,
    CFG_STRETCH_IN_TO  = 3'd2,
    CFG_FOOT_LEAVE_TO  = 3'd3,
    CFG_STRETCH_OUT_TM = 3'd4
  } lsmc_cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register reset values
  localparam logic [15:0] FootDwellRst      = 16'd100;
  localparam logic [15:0] InTimeoutRst      = 16'd2000;
  localparam logic [15:0] StretchInTimeoRst = 16'd1300;
  localparam logic [7:0]  FootLeaveRst      = 8'd20;
  localparam logic [15:0] StretchOutRst     = 16'd20;

  localparam logic [15:0] CntMax = 16'hFFFF;

  // Pending tick flags
  localparam int unsigned PendDuty  = 0;
  localparam int unsigned PendTime  = 1;
  localparam int unsigned PendDwell = 2;
  localparam logic [2:0]  PendAll   = 3'b111;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  mode;
    logic [7:0]  speed;
    logic        in_limit;
    logic        out_limit;
    logic        foot_on;
    logic        angle_on;
    logic        ground_on;
    logic        person_present;
    logic [15:0] preset_value;
  } lsmc_req_t;

  typedef struct packed {
    logic [3:0] status;
    logic       direction_in;
    logic       power_on;
    logic [8:0] duty;
  } lsmc_res_t;

  typedef struct packed {
    logic [15:0] foot_dwell_ticks;
    logic [15:0] in_timeout_ticks;
    logic [15:0] stretch_in_timeout_ticks;
    logic [7:0]  foot_leave_timeout;
    logic [15:0] stretch_out_time;
  } lsmc_cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/limit_switch_motor_controller_unit.sv =====
// Limit switch motor controller: top level with request and result registers.
//
// Usage:
//   Requests arrive on in_req_i under in_valid_i / in_stall_o and are taken
//   at a clock edge with valid high and stall low. Each request gives exactly
//   one result on out_res_o under out_valid_o / out_stall_i.
//   A request lands in the input register at the edge it is taken; it is
//   evaluated against the controller state and loaded into the result
//   register at an edge where the result register is free.
//   Throughput is one request per cycle while the receiver does not stall;
//   the single pass of decision logic between the two registers sets that figure.
//   When the receiver stalls, the result register holds its contents and
//   one more request may wait in the input register; in_stall_o rises only
//   when both are full and the result is still stalled.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i at
//   any edge with the write enable high; it should be changed while idle.
//   Reset (rst_ni low, asynchronous) empties both registers, restores the
//   register defaults and clears all timers, flags and the duty.
`default_nettype none

`include "limit_switch_motor_controller_unit_defines.svh"

module limit_switch_motor_controller_unit #(
  parameter int unsigned PWM_TOP = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire lsmc_pkg::lsmc_req_t           in_req_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output lsmc_pkg::lsmc_res_t                out_res_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [lsmc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [lsmc_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import lsmc_pkg::*;

  logic      in_valid_q, in_valid_d;
  lsmc_req_t in_req_q;
  logic      out_valid_q, out_valid_d;
  lsmc_res_t out_res_q;
  lsmc_res_t res;
  lsmc_cfg_t cfg;
  logic      out_free;
  logic      fire;
  logic      take;

  lsmc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lsmc_ctrl #(
    .PWM_TOP (PWM_TOP)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .req_i  (in_req_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Handshake: result register frees when empty or being taken
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (take)      in_valid_d = 1'b1;
    else if (fire) in_valid_d = 1'b0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire)             out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  // Control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (take) in_req_q <= in_req_i;
    if (fire) out_res_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  // A waiting request moves on whenever the result register is empty
  `LSMC_ASSERT(a_fire_when_free, clk_i, rst_ni, (in_valid_q && !out_valid_q) |=> out_valid_q)
  // The input side is held off only while both registers are full
  `LSMC_ASSERT(a_stall_only_full, clk_i, rst_ni, in_stall_o |-> (in_valid_q && out_valid_q))
  // Soft start never goes beyond the 8-bit speed range
  `LSMC_ASSERT_NEVER(a_duty_range, clk_i, rst_ni, out_valid_q && out_res_q.duty[8])
  // Requests other than steps (timer, preset, spare codes) report a running status
  `LSMC_ASSERT(a_tick_status, clk_i, rst_ni,
               (fire && in_req_q.cmd != CMD_STEP) |=> (out_res_q.status == STAT_RUN))

endmodule

`default_nettype wire

// ===== hw/rtl/lsmc_cfg_regs.sv =====
// Configuration register file of the limit switch motor controller.
`default_nettype none

module lsmc_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [lsmc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [lsmc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output lsmc_pkg::lsmc_cfg_t                 cfg_o
);
  import lsmc_pkg::*;

  lsmc_cfg_t cfg_q, cfg_d;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FOOT_DWELL:     cfg_d.foot_dwell_ticks         = cfg_wdata_i;
        CFG_IN_TIMEOUT:     cfg_d.in_timeout_ticks         = cfg_wdata_i;
        CFG_STRETCH_IN_TO:  cfg_d.stretch_in_timeout_ticks = cfg_wdata_i;
        CFG_FOOT_LEAVE_TO:  cfg_d.foot_leave_timeout       = cfg_wdata_i[7:0];
        CFG_STRETCH_OUT_TM: cfg_d.stretch_out_time         = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.foot_dwell_ticks         <= FootDwellRst;
      cfg_q.in_timeout_ticks         <= InTimeoutRst;
      cfg_q.stretch_in_timeout_ticks <= StretchInTimeoRst;
      cfg_q.foot_leave_timeout       <= FootLeaveRst;
      cfg_q.stretch_out_time         <= StretchOutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lsmc_ctrl.sv =====
// Controller state and single-pass decision logic for one request.
`default_nettype none

module lsmc_ctrl #(
  parameter int unsigned PWM_TOP = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire lsmc_pkg::lsmc_req_t req_i,
  input  wire lsmc_pkg::lsmc_cfg_t cfg_i,
  output lsmc_pkg::lsmc_res_t res_o
);
  import lsmc_pkg::*;

  localparam logic [8:0] HalfTop = 9'(PWM_TOP / 2);

  logic [2:0]   last_mode_q, last_mode_d;
  lsmc_end_e    end_pos_q, end_pos_d;
  logic [15:0]  dwell_q, dwell_d;
  logic [15:0]  in_timer_q, in_timer_d;
  logic [15:0]  sin_timer_q, sin_timer_d;
  logic [15:0]  elapsed_q, elapsed_d;
  logic [2:0]   pend_q, pend_d;
  logic [8:0]   duty_q, duty_d;
  logic         phase_q, phase_d;
  lsmc_status_e status;
  logic         run;
  logic         done;
  logic [7:0]   target;

  // Next state and stop reason for the request in hand
  always_comb begin
    last_mode_d = last_mode_q;
    end_pos_d   = end_pos_q;
    dwell_d     = dwell_q;
    in_timer_d  = in_timer_q;
    sin_timer_d = sin_timer_q;
    elapsed_d   = elapsed_q;
    pend_d      = pend_q;
    duty_d      = duty_q;
    phase_d     = phase_q;
    status      = STAT_RUN;
    run         = 1'b0;
    done        = 1'b0;
    target      = 8'd0;

    case (req_i.cmd)
      CMD_TICK_10MS: pend_d = PendAll;
      CMD_TICK_100MS: begin
        if (elapsed_q != CntMax) elapsed_d = elapsed_q + 16'd1;
      end
      CMD_PRESET_STRETCH: sin_timer_d = req_i.preset_value;
      CMD_PRESET_ELAPSED: elapsed_d   = req_i.preset_value;
      CMD_STEP: begin
        // a mode change forgets the end position
        if (last_mode_q != req_i.mode) begin
          last_mode_d = req_i.mode;
          end_pos_d   = END_NONE;
        end
        case (req_i.mode)
          MODE_IN, MODE_RESET, MODE_STRETCH_RESET: begin
            if (req_i.in_limit || end_pos_d == END_IN) begin
              end_pos_d = END_IN;
              status    = STAT_AT_IN;
            end else begin
              if (req_i.mode == MODE_IN) begin
                // foot dwell, then the inward timeout
                if (req_i.foot_on && pend_d[PendDwell]) begin
                  if (dwell_d != CntMax) dwell_d = dwell_d + 16'd1;
                  pend_d[PendDwell] = 1'b0;
                end
                if (req_i.foot_on && dwell_d >= cfg_i.foot_dwell_ticks) begin
                  dwell_d = 16'd0;
                  status  = STAT_AT_FOOT;
                  done    = 1'b1;
                end else begin
                  if (in_timer_d < cfg_i.in_timeout_ticks && pend_d[PendTime]) begin
                    pend_d[PendTime] = 1'b0;
                    in_timer_d       = in_timer_d + 16'd1;
                  end
                  if (in_timer_d >= cfg_i.in_timeout_ticks) begin
                    dwell_d = 16'd0;
                    status  = STAT_AT_FOOT;
                    done    = 1'b1;
                  end
                end
              end else if (req_i.mode == MODE_STRETCH_RESET) begin
                if (sin_timer_d < cfg_i.stretch_in_timeout_ticks && pend_d[PendTime]) begin
                  pend_d[PendTime] = 1'b0;
                  sin_timer_d      = sin_timer_d + 16'd1;
                end
                if (sin_timer_d >= cfg_i.stretch_in_timeout_ticks) begin
                  dwell_d = 16'd0;
                  status  = STAT_AT_FOOT;
                  done    = 1'b1;
                end
              end
              if (!done) begin
                end_pos_d = END_NONE;
                phase_d   = 1'b1;
                run       = 1'b1;
              end
            end
          end
          MODE_OUT, MODE_STRETCH_OUT, MODE_MANUAL_OUT, MODE_TEST_OUT: begin
            if (req_i.out_limit || end_pos_d == END_OUT) begin
              end_pos_d = END_OUT;
              status    = STAT_AT_OUT;
              if (req_i.mode == MODE_MANUAL_OUT) in_timer_d = 16'd0;
            end else begin
              if (req_i.mode == MODE_MANUAL_OUT) begin
                if (req_i.ground_on) begin
                  status = STAT_GROUND;
                  done   = 1'b1;
                end else if (req_i.angle_on) begin
                  status = STAT_ANGLE;
                  done   = 1'b1;
                end
              end else if (req_i.mode != MODE_TEST_OUT) begin
                if (req_i.angle_on) begin
                  status = STAT_ANGLE;
                  done   = 1'b1;
                end else if (req_i.ground_on) begin
                  status = STAT_GROUND;
                  done   = 1'b1;
                end else begin
                  // foot seen: flagged while the motor keeps running
                  if (req_i.foot_on) status = STAT_AT_FOOT;
                  if (req_i.mode == MODE_OUT) begin
                    if (!req_i.foot_on &&
                        elapsed_d > {8'd0, cfg_i.foot_leave_timeout}) begin
                      status = STAT_FOOT_LEFT;
                      done   = 1'b1;
                    end
                  end else if (req_i.person_present) begin
                    if (!req_i.foot_on) begin
                      status = STAT_FOOT_LEFT;
                      done   = 1'b1;
                    end
                  end else if (elapsed_d > cfg_i.stretch_out_time) begin
                    status = STAT_STRETCH_TO;
                    done   = 1'b1;
                  end
                  if (!done) in_timer_d = 16'd0;
                end
              end
              if (!done) begin
                end_pos_d = END_NONE;
                phase_d   = 1'b0;
                run       = 1'b1;
              end
            end
          end
          default: begin
            end_pos_d  = END_NONE;
            in_timer_d = 16'd0;
            status     = STAT_IDLE;
          end
        endcase

        // soft start: jump to half scale, then one per duty tick
        target = run ? req_i.speed : 8'd0;
        if (target == 8'd0) begin
          duty_d = 9'd0;
        end else if (pend_d[PendDuty]) begin
          pend_d[PendDuty] = 1'b0;
          if (duty_d < {1'b0, target}) begin
            if (duty_d < HalfTop) duty_d = HalfTop;
            else                  duty_d = duty_d + 9'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // State update on each request evaluated
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_mode_q <= MODE_IDLE;
      end_pos_q   <= END_NONE;
      dwell_q     <= 16'd0;
      in_timer_q  <= 16'd0;
      sin_timer_q <= 16'd0;
      elapsed_q   <= 16'd0;
      pend_q      <= 3'd0;
      duty_q      <= 9'd0;
      phase_q     <= 1'b0;
    end else if (step_i) begin
      last_mode_q <= last_mode_d;
      end_pos_q   <= end_pos_d;
      dwell_q     <= dwell_d;
      in_timer_q  <= in_timer_d;
      sin_timer_q <= sin_timer_d;
      elapsed_q   <= elapsed_d;
      pend_q      <= pend_d;
      duty_q      <= duty_d;
      phase_q     <= phase_d;
    end
  end

  // Result as it stands after the request
  always_comb begin
    res_o.status       = status;
    res_o.direction_in = phase_d;
    res_o.power_on     = (duty_d != 9'd0);
    res_o.duty         = duty_d;
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the limit switch motor controller unit.
`default_nettype none

module tb;
  import lsmc_pkg::*;

  localparam int unsigned PwmTop        = 256;
  localparam logic [8:0]  DutyHalf      = 9'(PwmTop / 2);
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned MaxReports    = 10;

  // Spare command codes that the block ignores
  localparam logic [2:0] CmdSpareLo = 3'd5;
  localparam logic [2:0] CmdSpareHi = 3'd7;

  // Switch levels, packed in request field order
  localparam logic [5:0] SwNone   = 6'b000000;
  localparam logic [5:0] SwIn     = 6'b100000;
  localparam logic [5:0] SwOut    = 6'b010000;
  localparam logic [5:0] SwFoot   = 6'b001000;
  localparam logic [5:0] SwAngle  = 6'b000100;
  localparam logic [5:0] SwGround = 6'b000010;
  localparam logic [5:0] SwPerson = 6'b000001;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  lsmc_req_t           in_req_i;
  logic                out_valid_o;
  logic                out_stall_i;
  lsmc_res_t           out_res_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  // Shadow of the controller state and registers
  lsmc_cfg_t   ctl_cfg;
  logic [2:0]  ctl_last_mode;
  logic [1:0]  ctl_end;
  logic [15:0] ctl_dwell;
  logic [15:0] ctl_in_timer;
  logic [15:0] ctl_stretch_timer;
  logic [15:0] ctl_elapsed;
  logic [2:0]  ctl_pending;
  logic [8:0]  ctl_duty;
  logic        ctl_phase_in;

  lsmc_res_t motor_out_q[$];
  int        err_count = 0;
  int        stuck_cycles = 0;
  int        stall_run = 0;
  bit        idling_on;
  bit        quiet_tail;

  limit_switch_motor_controller_unit #(
    .PWM_TOP(PwmTop)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow state after reset
  task automatic reset_prediction();
    ctl_cfg.foot_dwell_ticks         = FootDwellRst;
    ctl_cfg.in_timeout_ticks         = InTimeoutRst;
    ctl_cfg.stretch_in_timeout_ticks = StretchInTimeoRst;
    ctl_cfg.foot_leave_timeout       = FootLeaveRst;
    ctl_cfg.stretch_out_time         = StretchOutRst;
    ctl_last_mode     = MODE_IDLE;
    ctl_end           = END_NONE;
    ctl_dwell         = '0;
    ctl_in_timer      = '0;
    ctl_stretch_timer = '0;
    ctl_elapsed       = '0;
    ctl_pending       = '0;
    ctl_duty          = '0;
    ctl_phase_in      = 1'b0;
  endtask

  // One timeout tick per pending flag, never past the limit
  function automatic logic [15:0] timer_advance(input logic [15:0] t, input logic [15:0] lim);
    if (t < lim && ctl_pending[PendTime]) begin
      ctl_pending[PendTime] = 1'b0;
      return t + 16'd1;
    end
    return t;
  endfunction

  // Next motor outputs for one request; updates the shadow state
  function automatic lsmc_res_t predict_motor(input lsmc_req_t r);
    logic [3:0] st;
    logic       run;
    logic       stop;
    logic [7:0] target;
    lsmc_res_t  res;
    st   = STAT_RUN;
    run  = 1'b0;
    stop = 1'b0;
    case (r.cmd)
      CMD_TICK_10MS: ctl_pending = PendAll;
      CMD_TICK_100MS: if (ctl_elapsed != CntMax) ctl_elapsed = ctl_elapsed + 16'd1;
      CMD_PRESET_STRETCH: ctl_stretch_timer = r.preset_value;
      CMD_PRESET_ELAPSED: ctl_elapsed = r.preset_value;
      CMD_STEP: begin
        if (ctl_last_mode != r.mode) begin
          ctl_last_mode = r.mode;
          ctl_end = END_NONE;
        end
        case (r.mode)
          MODE_IN, MODE_RESET, MODE_STRETCH_RESET: begin
            if (r.in_limit || ctl_end == END_IN) begin
              ctl_end = END_IN;
              st = STAT_AT_IN;
            end else begin
              if (r.mode == MODE_IN) begin
                if (r.foot_on && ctl_pending[PendDwell]) begin
                  if (ctl_dwell != CntMax) ctl_dwell = ctl_dwell + 16'd1;
                  ctl_pending[PendDwell] = 1'b0;
                end
                if (r.foot_on && ctl_dwell >= ctl_cfg.foot_dwell_ticks) begin
                  stop = 1'b1;
                end else begin
                  ctl_in_timer = timer_advance(ctl_in_timer, ctl_cfg.in_timeout_ticks);
                  stop = (ctl_in_timer >= ctl_cfg.in_timeout_ticks);
                end
              end else if (r.mode == MODE_STRETCH_RESET) begin
                ctl_stretch_timer = timer_advance(ctl_stretch_timer,
                                                  ctl_cfg.stretch_in_timeout_ticks);
                stop = (ctl_stretch_timer >= ctl_cfg.stretch_in_timeout_ticks);
              end
              if (stop) begin
                ctl_dwell = '0;
                st = STAT_AT_FOOT;
              end else begin
                ctl_end = END_NONE;
                ctl_phase_in = 1'b1;
                run = 1'b1;
              end
            end
          end
          MODE_OUT, MODE_STRETCH_OUT, MODE_MANUAL_OUT, MODE_TEST_OUT: begin
            if (r.out_limit || ctl_end == END_OUT) begin
              ctl_end = END_OUT;
              st = STAT_AT_OUT;
              if (r.mode == MODE_MANUAL_OUT) ctl_in_timer = '0;
            end else begin
              if (r.mode == MODE_MANUAL_OUT) begin
                if (r.ground_on) begin
                  st = STAT_GROUND;
                  stop = 1'b1;
                end else if (r.angle_on) begin
                  st = STAT_ANGLE;
                  stop = 1'b1;
                end
              end else if (r.mode != MODE_TEST_OUT) begin
                if (r.angle_on) begin
                  st = STAT_ANGLE;
                  stop = 1'b1;
                end else if (r.ground_on) begin
                  st = STAT_GROUND;
                  stop = 1'b1;
                end else begin
                  // foot contact is reported while the motor keeps going
                  if (r.foot_on) st = STAT_AT_FOOT;
                  if (r.mode == MODE_OUT) begin
                    if (!r.foot_on && ctl_elapsed > {8'h00, ctl_cfg.foot_leave_timeout}) begin
                      st = STAT_FOOT_LEFT;
                      stop = 1'b1;
                    end
                  end else if (r.person_present) begin
                    if (!r.foot_on) begin
                      st = STAT_FOOT_LEFT;
                      stop = 1'b1;
                    end
                  end else if (ctl_elapsed > ctl_cfg.stretch_out_time) begin
                    st = STAT_STRETCH_TO;
                    stop = 1'b1;
                  end
                  if (!stop) ctl_in_timer = '0;
                end
              end
              if (!stop) begin
                ctl_end = END_NONE;
                ctl_phase_in = 1'b0;
                run = 1'b1;
              end
            end
          end
          default: begin
            ctl_end = END_NONE;
            ctl_in_timer = '0;
            st = STAT_IDLE;
          end
        endcase
        // soft start: jump to half scale, then one step per duty tick
        target = run ? r.speed : 8'd0;
        if (target == 8'd0) begin
          ctl_duty = '0;
        end else if (ctl_pending[PendDuty]) begin
          ctl_pending[PendDuty] = 1'b0;
          if (ctl_duty < {1'b0, target}) begin
            if (ctl_duty < DutyHalf) ctl_duty = DutyHalf;
            else ctl_duty = ctl_duty + 9'd1;
          end
        end
      end
      default: ;
    endcase
    res.status       = st;
    res.direction_in = ctl_phase_in;
    res.power_on     = (ctl_duty != '0);
    res.duty         = ctl_duty;
    return res;
  endfunction

  function automatic lsmc_req_t mk_req(input logic [2:0] cmd, input logic [2:0] mode,
                                       input logic [7:0] speed, input logic [5:0] sw,
                                       input logic [15:0] preset);
    return {cmd, mode, speed, sw, preset};
  endfunction

  function automatic logic [15:0] pick_limit();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 25));
  endfunction

  function automatic lsmc_cfg_t random_cfg();
    lsmc_cfg_t c;
    c.foot_dwell_ticks         = pick_limit();
    c.in_timeout_ticks         = pick_limit();
    c.stretch_in_timeout_ticks = pick_limit();
    c.foot_leave_timeout       = 8'(pick_limit());
    c.stretch_out_time         = pick_limit();
    return c;
  endfunction

  // Send one request, with an optional gap before it
  task automatic send_req(input lsmc_req_t r);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    motor_out_q.push_back(predict_motor(r));
  endtask

  // Hold the sender off until every result is back
  task automatic wait_results();
    in_valid_i <= 1'b0;
    while (motor_out_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic put_cfg(input lsmc_cfg_idx_e idx, input logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
  endtask

  task automatic write_cfg(input lsmc_cfg_t c);
    put_cfg(CFG_FOOT_DWELL, c.foot_dwell_ticks);
    put_cfg(CFG_IN_TIMEOUT, c.in_timeout_ticks);
    put_cfg(CFG_STRETCH_IN_TO, c.stretch_in_timeout_ticks);
    put_cfg(CFG_FOOT_LEAVE_TO, {8'h00, c.foot_leave_timeout});
    put_cfg(CFG_STRETCH_OUT_TM, c.stretch_out_time);
    cfg_we_i <= 1'b0;
    ctl_cfg = c;
  endtask

  // Runs of one mode with ticks, presets and switch changes mixed in
  task automatic run_random(input int n_items);
    lsmc_req_t base;
    lsmc_req_t r;
    int        sent;
    int        seq_len;
    int        pick;
    sent = 0;
    while (sent < n_items) begin
      if (!quiet_tail) idling_on = ($urandom_range(0, 4) != 0);
      base.cmd            = CMD_STEP;
      base.mode           = 3'($urandom_range(0, 7));
      pick                = $urandom_range(0, 7);
      base.speed          = (pick == 0) ? 8'd0 : (pick == 1) ? 8'hFF : 8'($urandom);
      base.in_limit       = ($urandom_range(0, 5) == 0);
      base.out_limit      = ($urandom_range(0, 5) == 0);
      base.foot_on        = ($urandom_range(0, 1) == 0);
      base.angle_on       = ($urandom_range(0, 5) == 0);
      base.ground_on      = ($urandom_range(0, 5) == 0);
      base.person_present = ($urandom_range(0, 1) == 0);
      base.preset_value   = '0;
      seq_len = $urandom_range(4, 40);
      for (int k = 0; k < seq_len; k++) begin
        // now and then a switch changes level within the run
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 5))
            0: base.in_limit = ~base.in_limit;
            1: base.out_limit = ~base.out_limit;
            2: base.foot_on = ~base.foot_on;
            3: base.angle_on = ~base.angle_on;
            4: base.ground_on = ~base.ground_on;
            default: base.person_present = ~base.person_present;
          endcase
        end
        r = base;
        r.preset_value = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 40))
                                                     : 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 45) r.cmd = CMD_STEP;
        else if (pick < 80) r.cmd = CMD_TICK_10MS;
        else if (pick < 88) r.cmd = CMD_TICK_100MS;
        else if (pick < 92) r.cmd = CMD_PRESET_STRETCH;
        else if (pick < 95) r.cmd = CMD_PRESET_ELAPSED;
        else if (pick < 97) r.cmd = 3'($urandom_range(CmdSpareLo, CmdSpareHi));
        else begin
          r.cmd  = CMD_STEP;
          r.mode = 3'($urandom_range(0, 7));
        end
        send_req(r);
        if (r.cmd < CmdSpareLo) sent++;
      end
    end
  endtask

  task automatic test_reset();
    reset_prediction();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  endtask

  // Every mode but MODE_IN, every command, sticky ends, soft start, saturation
  task automatic test_directed_motion();
    send_req(mk_req(CMD_STEP, MODE_IDLE, 8'hFF, 6'b111111, 16'hFFFF));
    for (int c = CmdSpareLo; c <= CmdSpareHi; c++)
      send_req(mk_req(3'(c), 3'($urandom), 8'($urandom), 6'($urandom), 16'($urandom)));
    send_req(mk_req(CMD_TICK_10MS, MODE_IDLE, 8'd0, SwNone, 16'd0));
    send_req(mk_req(CMD_STEP, MODE_OUT, 8'hFF, SwFoot, 16'd0));
    send_req(mk_req(CMD_TICK_10MS, MODE_OUT, 8'd0, SwNone, 16'd0));
    send_req(mk_req(CMD_STEP, MODE_OUT, 8'hFF, SwFoot, 16'd0));
    send_req(mk_req(CMD_STEP, MODE_OUT, 8'hFF, SwOut, 16'd0));
    send_req(mk_req(CMD_STEP, MODE_OUT, 8'hFF, SwNone, 16'd0));
    send_req(mk_req(CMD_STEP, MODE_MANUAL_OUT, 8'hFF, SwGround | SwAngle, 16'd0));
    send_req(mk_req(CMD_STEP, MODE_TEST_OUT, 8'd0, SwGround | SwAngle, 16'd0));
    // elapsed counter pinned at its top
    send_req(mk_req(CMD_PRESET_ELAPSED, MODE_IDLE, 8'd0, SwNone, 16'hFFFF));
    send_req(mk_req(CMD_TICK_100MS, MODE_IDLE, 8'd0, SwNone, 16'd0));
    send_req(mk_req(CMD_STEP, MODE_OUT, 8'd128, SwNone, 16'd0));
    send_req(mk_req(CMD_STEP, MODE_STRETCH_OUT, 8'd128, SwPerson, 16'd0));
    send_req(mk_req(CMD_STEP, MODE_STRETCH_OUT, 8'd128, SwNone, 16'd0));
    send_req(mk_req(CMD_STEP, MODE_RESET, 8'hFF, SwIn, 16'd0));
    send_req(mk_req(CMD_STEP, MODE_RESET, 8'hFF, SwNone, 16'd0));
    send_req(mk_req(CMD_PRESET_STRETCH, MODE_IDLE, 8'd0, SwNone, 16'hFFFF));
    send_req(mk_req(CMD_STEP, MODE_STRETCH_RESET, 8'hFF, SwNone, 16'd0));
  endtask

  // Foot dwell stop, inward timeout that holds, zero limit
  task automatic test_inward_timeouts();
    lsmc_cfg_t c;
    wait_results();
    c.foot_dwell_ticks         = 16'd1;
    c.in_timeout_ticks         = 16'd2;
    c.stretch_in_timeout_ticks = '0;
    c.foot_leave_timeout       = '0;
    c.stretch_out_time         = '1;
    write_cfg(c);
    send_req(mk_req(CMD_STEP, MODE_IDLE, 8'd0, SwNone, 16'd0));
    repeat (2) begin
      send_req(mk_req(CMD_TICK_10MS, MODE_IDLE, 8'd0, SwNone, 16'd0));
      send_req(mk_req(CMD_STEP, MODE_IN, 8'd200, SwFoot, 16'd0));
    end
    repeat (2) begin
      send_req(mk_req(CMD_TICK_10MS, MODE_IDLE, 8'd0, SwNone, 16'd0));
      send_req(mk_req(CMD_STEP, MODE_IN, 8'd200, SwNone, 16'd0));
    end
    send_req(mk_req(CMD_STEP, MODE_IN, 8'd200, SwNone, 16'd0));
    send_req(mk_req(CMD_STEP, MODE_STRETCH_RESET, 8'd200, SwNone, 16'd0));
  endtask

  // Register settings from all zero and all ones to random ones
  task automatic test_config_sweep();
    lsmc_cfg_t c;
    for (int p = 0; p < 6; p++) begin
      c = random_cfg();
      if (p == 0) c = '0;
      else if (p == 1) c = '1;
      wait_results();
      write_cfg(c);
      run_random(250);
    end
  endtask

  task automatic test_quiet_tail();
    quiet_tail = 1'b1;
    idling_on  = 1'b0;
    wait_results();
    write_cfg(random_cfg());
    run_random(420);
  endtask

  // Receiver stall bursts
  always @(posedge clk_i) begin
    if (stall_run > 0) begin
      stall_run--;
      if (stall_run == 0) out_stall_i <= 1'b0;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      stall_run = $urandom_range(1, 12);
      out_stall_i <= 1'b1;
    end
  end

  // Result check, sampled on the falling edge before the taking edge
  always @(negedge clk_i) begin
    lsmc_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (motor_out_q.size() == 0) begin
        if (err_count < MaxReports)
          $display("unexpected result: status %0d dir %0b pwr %0b duty %0d",
                   out_res_o.status, out_res_o.direction_in, out_res_o.power_on,
                   out_res_o.duty);
        err_count++;
      end else begin
        want = motor_out_q.pop_front();
        if (out_res_o.status !== want.status || out_res_o.direction_in !== want.direction_in ||
            out_res_o.power_on !== want.power_on || out_res_o.duty !== want.duty) begin
          if (err_count < MaxReports)
            $display("mismatch: exp status %0d dir %0b pwr %0b duty %0d, got %0d %0b %0b %0d",
                     want.status, want.direction_in, want.power_on, want.duty,
                     out_res_o.status, out_res_o.direction_in, out_res_o.power_on,
                     out_res_o.duty);
          err_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(negedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    idling_on   = 1'b1;
    quiet_tail  = 1'b0;
    test_reset();
    test_directed_motion();
    test_inward_timeouts();
    test_config_sweep();
    test_quiet_tail();
    wait_results();
    repeat (8) @(posedge clk_i);
    if (err_count == 0 && motor_out_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
